FILE: hw/rtl/bltq_pkg.sv
// Shared types and constants for the bintree terrain height query block.
package bltq_pkg;

  localparam int COORD_W = 9;
  localparam int ACC_W = 42;
  localparam int MAG_W = 41;
  localparam int DIVR_W = 20;
  localparam int DESCENT_LIMIT = 64;

  typedef enum logic [1:0] {
    OP_WR_HEIGHT = 2'd0,
    OP_WR_ACT    = 2'd1,
    OP_QUERY     = 2'd2,
    OP_NONE      = 2'd3
  } bltq_op_t;

  typedef enum logic [0:0] {
    CFG_LOG_WIDTH  = 1'b0,
    CFG_LOG_HEIGHT = 1'b1
  } bltq_cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TEST, S_NR0, S_NR1, S_NL0, S_NL1, S_DEC,
    S_RA, S_RR, S_RL, S_RW, S_D0, S_D1, S_S0, S_S1, S_S2,
    S_DST, S_DIV, S_HFIN, S_DONE
  } bltq_state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic signed [15:0] write_value;
    logic [7:0]         lod_level;
    logic [COORD_W-1:0] apex_x;
    logic [COORD_W-1:0] apex_y;
    logic [COORD_W-1:0] right_x;
    logic [COORD_W-1:0] right_y;
    logic [COORD_W-1:0] left_x;
    logic [COORD_W-1:0] left_y;
  } bltq_in_t;

  typedef struct packed {
    logic signed [15:0] query_height;
    logic               base_reached;
  } bltq_out_t;

endpackage

FILE: hw/rtl/bltq_div.sv
// Restoring divider with floor rounding of a signed dividend, low 16 quotient bits out.
module bltq_div
  import bltq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              neg,
  input  logic [MAG_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              done,
  output logic [15:0]       quot
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]  dvd_r, dvd_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] dvs_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;

  always_comb begin
    trial = {rem_r, dvd_r[MAG_W-1]};
    diff = trial - {1'b0, dvs_r};
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(MAG_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DIVR_W-1:0];
        dvd_nxt = {dvd_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVR_W-1:0];
        dvd_nxt = {dvd_r[MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
      neg_r <= neg;
    end
  end

  always_comb begin
    if (!neg_r) begin
      quot = dvd_r[15:0];
    end else if (rem_r != '0) begin
      quot = ~dvd_r[15:0];
    end else begin
      quot = ~dvd_r[15:0] + 16'd1;
    end
  end

  assign done = done_r;

endmodule

FILE: hw/rtl/bintree_lod_height_query.sv
// Top level of the bintree terrain height query block.
// Usage: words enter on in_valid/in_stall and leave on out_valid/out_stall.
// A height or activation write is taken while idle and gives no result.
// A query walks down the right-triangle bintree one level per iteration.
// Each level is a vertex test with the activation read, four passes
// through the shared multiply-accumulate unit for the two barycentric
// numerators, and a descent decision. A vertex hit or base stop goes
// from its test through S_HFIN, which captures the height, to S_DONE.
// A stop that interpolates runs, after its decision, three height reads
// and their capture, five MAC passes, the divider start, the restoring
// division and the output load. in_stall is high while a query is in work.
// The result sits in an output register; the next word is accepted while
// it waits, and a new result waits until the receiver takes the old one.
// Reset sets both grid logs to 8 (clamped to LOG_SIDE) and empties the
// output; the grid memories are not cleared and must be written first.
module bintree_lod_height_query
  import bltq_pkg::*;
#(
  parameter int LOG_SIDE = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bltq_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output bltq_out_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int SIDE_MAX = (1 << LOG_SIDE) + 1;
  localparam int STORE_DEPTH = SIDE_MAX * SIDE_MAX;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int RST_LOG = (LOG_SIDE < 8) ? LOG_SIDE : 8;
  localparam int STEP_W = $clog2(DESCENT_LIMIT + 1);

  function automatic logic [IDX_W-1:0] grid_idx(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [3:0] lw);
    logic [31:0] t;
    t = (32'(y) << lw) + 32'(y) + 32'(x);
    return t[IDX_W-1:0];
  endfunction

  function automatic logic on_grid(input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y,
                                   input logic [3:0] lw, input logic [3:0] lh);
    logic [16:0] wl;
    logic [16:0] hl;
    wl = 17'd1 << lw;
    hl = 17'd1 << lh;
    return (17'(x) <= wl) && (17'(y) <= hl);
  endfunction

  function automatic logic [3:0] clamp_log(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v < 4'd1) r = 4'd1;
    if (v > 4'(LOG_SIDE)) r = 4'(LOG_SIDE);
    return r;
  endfunction

  logic signed [15:0] hmem [STORE_DEPTH];
  logic [7:0]         amem [STORE_DEPTH];

  bltq_state_t state_r, state_nxt;
  logic [3:0]  lw_r, lh_r;
  logic        out_valid_r;
  bltq_out_t   out_r;

  logic [COORD_W-1:0] px_r, py_r, ax_r, ay_r, rx_r, ry_r, lx_r, ly_r, bx_r, by_r;
  logic [7:0]         level_r;
  logic [STEP_W-1:0]  step_r;
  logic               base_r;
  logic signed [19:0] nr_r, nl_r;
  logic signed [15:0] az_r;
  logic signed [16:0] dr_r, dl_r;
  logic [18:0]        d_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [15:0] res_r;

  logic               wr_take, q_take;
  logic [IDX_W-1:0]   wr_idx;
  logic               wr_ok;

  logic               hrd_en, ard_en;
  logic [COORD_W-1:0] rd_x, rd_y;
  logic signed [15:0] hq_r;
  logic               hoff_r;
  logic [7:0]         aq_r;
  logic               aoff_r;
  logic signed [15:0] hval;
  logic [7:0]         aval;

  logic signed [9:0]  dx, dy, dpx, dpy, drx, dry, dlx, dly;
  logic signed [10:0] bxs, bys;
  logic               vhit, at_base;
  logic signed [20:0] mul_a, mul_b;
  logic signed [ACC_W-1:0] prod;

  logic               div_start, div_done, div_neg;
  logic [MAG_W-1:0]   div_mag;
  logic signed [ACC_W-1:0] acc_abs;
  logic [15:0]        div_q;

  assign wr_take = in_valid && !in_stall &&
                   ((in_data.operation == OP_WR_HEIGHT) || (in_data.operation == OP_WR_ACT));
  assign q_take = in_valid && !in_stall && (in_data.operation == OP_QUERY);
  assign wr_idx = grid_idx(in_data.point_x, in_data.point_y, lw_r);
  assign wr_ok = on_grid(in_data.point_x, in_data.point_y, lw_r, lh_r);

  assign dx = $signed({1'b0, lx_r}) - $signed({1'b0, rx_r});
  assign dy = $signed({1'b0, ly_r}) - $signed({1'b0, ry_r});
  assign dpx = $signed({1'b0, px_r}) - $signed({1'b0, ax_r});
  assign dpy = $signed({1'b0, py_r}) - $signed({1'b0, ay_r});
  assign drx = $signed({1'b0, rx_r}) - $signed({1'b0, ax_r});
  assign dry = $signed({1'b0, ry_r}) - $signed({1'b0, ay_r});
  assign dlx = $signed({1'b0, lx_r}) - $signed({1'b0, ax_r});
  assign dly = $signed({1'b0, ly_r}) - $signed({1'b0, ay_r});
  assign bxs = $signed({2'b0, rx_r}) + 11'(dx >>> 1);
  assign bys = $signed({2'b0, ry_r}) + 11'(dy >>> 1);
  assign vhit = (step_r != STEP_W'(DESCENT_LIMIT)) &&
                ((px_r == ax_r && py_r == ay_r) || (px_r == rx_r && py_r == ry_r) ||
                 (px_r == lx_r && py_r == ly_r));
  assign at_base = (dx >= -10'sd1 && dx <= 10'sd1 && dy >= -10'sd1 && dy <= 10'sd1) ||
                   (step_r == STEP_W'(DESCENT_LIMIT));

  assign hval = hoff_r ? 16'sd0 : hq_r;
  assign aval = aoff_r ? 8'd0 : aq_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_take) state_nxt = S_TEST;
      S_TEST: begin
        if (vhit || at_base) state_nxt = S_HFIN;
        else state_nxt = S_NR0;
      end
      S_NR0:  state_nxt = S_NR1;
      S_NR1:  state_nxt = S_NL0;
      S_NL0:  state_nxt = S_NL1;
      S_NL1:  state_nxt = S_DEC;
      S_DEC:  state_nxt = (aval >= level_r) ? S_TEST : S_RA;
      S_RA:   state_nxt = S_RR;
      S_RR:   state_nxt = S_RL;
      S_RL:   state_nxt = S_RW;
      S_RW:   state_nxt = S_D0;
      S_D0:   state_nxt = S_D1;
      S_D1:   state_nxt = S_S0;
      S_S0:   state_nxt = S_S1;
      S_S1:   state_nxt = S_S2;
      S_S2:   state_nxt = S_DST;
      S_DST:  state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_DONE;
      S_HFIN: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    hrd_en = 1'b0;
    ard_en = 1'b0;
    rd_x = ax_r;
    rd_y = ay_r;
    mul_a = '0;
    mul_b = '0;
    acc_nxt = acc_r;
    div_start = 1'b0;
    unique case (state_r)
      S_TEST: begin
        if (vhit) begin
          hrd_en = 1'b1;
          rd_x = px_r;
          rd_y = py_r;
        end else if (at_base) begin
          hrd_en = 1'b1;
        end else begin
          ard_en = 1'b1;
          rd_x = bxs[COORD_W-1:0];
          rd_y = bys[COORD_W-1:0];
        end
      end
      S_NR0: begin
        mul_a = 21'(dpx);
        mul_b = 21'(drx);
        acc_nxt = prod;
      end
      S_NR1: begin
        mul_a = 21'(dpy);
        mul_b = 21'(dry);
        acc_nxt = acc_r + prod;
      end
      S_NL0: begin
        mul_a = 21'(dpx);
        mul_b = 21'(dlx);
        acc_nxt = prod;
      end
      S_NL1: begin
        mul_a = 21'(dpy);
        mul_b = 21'(dly);
        acc_nxt = acc_r + prod;
      end
      S_RA: hrd_en = 1'b1;
      S_RR: begin
        hrd_en = 1'b1;
        rd_x = rx_r;
        rd_y = ry_r;
      end
      S_RL: begin
        hrd_en = 1'b1;
        rd_x = lx_r;
        rd_y = ly_r;
      end
      S_D0: begin
        mul_a = 21'(dx);
        mul_b = 21'(dx);
        acc_nxt = prod;
      end
      S_D1: begin
        mul_a = 21'(dy);
        mul_b = 21'(dy);
        acc_nxt = acc_r + prod;
      end
      S_S0: begin
        mul_a = 21'(nl_r);
        mul_b = 21'(dl_r);
        acc_nxt = prod;
      end
      S_S1: begin
        mul_a = 21'(nr_r);
        mul_b = 21'(dr_r);
        acc_nxt = acc_r + prod;
      end
      S_S2: begin
        mul_a = 21'(az_r);
        mul_b = $signed({1'b0, d_r, 1'b0});
        acc_nxt = (acc_r <<< 2) + prod + $signed(ACC_W'(d_r));
      end
      S_DST: div_start = 1'b1;
      default: ;
    endcase
  end

  assign prod = ACC_W'(mul_a) * ACC_W'(mul_b);
  assign div_neg = acc_r[ACC_W-1];
  assign acc_abs = div_neg ? -acc_r : acc_r;
  assign div_mag = acc_abs[MAG_W-1:0];

  bltq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .neg      (div_neg),
    .dividend (div_mag),
    .divisor  ({d_r, 1'b0}),
    .done     (div_done),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (wr_take && wr_ok) begin
      if (in_data.operation == OP_WR_HEIGHT) hmem[wr_idx] <= in_data.write_value;
      else amem[wr_idx] <= in_data.write_value[7:0];
    end
    if (hrd_en) begin
      hq_r <= hmem[grid_idx(rd_x, rd_y, lw_r)];
      hoff_r <= !on_grid(rd_x, rd_y, lw_r, lh_r);
    end
    if (ard_en) begin
      aq_r <= amem[grid_idx(rd_x, rd_y, lw_r)];
      aoff_r <= !on_grid(rd_x, rd_y, lw_r, lh_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (q_take) begin
      px_r <= in_data.point_x;
      py_r <= in_data.point_y;
      level_r <= in_data.lod_level;
      ax_r <= in_data.apex_x;
      ay_r <= in_data.apex_y;
      rx_r <= in_data.right_x;
      ry_r <= in_data.right_y;
      lx_r <= in_data.left_x;
      ly_r <= in_data.left_y;
      step_r <= '0;
    end
    case (state_r)
      S_TEST: begin
        base_r <= !vhit && at_base;
        bx_r <= bxs[COORD_W-1:0];
        by_r <= bys[COORD_W-1:0];
      end
      S_NR1: nr_r <= acc_nxt[19:0];
      S_NL1: nl_r <= acc_nxt[19:0];
      S_DEC: begin
        if (aval >= level_r) begin
          if (nr_r >= nl_r) begin
            lx_r <= rx_r;
            ly_r <= ry_r;
            rx_r <= ax_r;
            ry_r <= ay_r;
          end else begin
            rx_r <= lx_r;
            ry_r <= ly_r;
            lx_r <= ax_r;
            ly_r <= ay_r;
          end
          ax_r <= bx_r;
          ay_r <= by_r;
          step_r <= step_r + 1'b1;
        end
      end
      S_RR: az_r <= hval;
      S_RL: dr_r <= 17'(hval) - 17'(az_r);
      S_RW: dl_r <= 17'(hval) - 17'(az_r);
      S_D1: d_r <= acc_nxt[18:0];
      S_DIV: if (div_done) res_r <= div_q;
      S_HFIN: res_r <= hval;
      default: ;
    endcase
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_r.query_height <= res_r;
      out_r.base_reached <= base_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      lw_r <= 4'(RST_LOG);
      lh_r <= 4'(RST_LOG);
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_LOG_WIDTH) lw_r <= clamp_log(cfg_data);
        else lh_r <= clamp_log(cfg_data);
      end
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

FILE: sim/tb.sv
// Testbench for the bintree terrain height query block: scoreboard against a behavioral predictor.
module tb;
  import bltq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOG_SIDE = 8;
  localparam int SIDE_MAX = (1 << LOG_SIDE) + 1;
  localparam int DEPTH = SIDE_MAX * SIDE_MAX;
  localparam int WATCHDOG_LIMIT = 6000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  bltq_in_t in_word;
  logic out_valid;
  logic out_stall;
  bltq_out_t out_word;
  logic cfg_we;
  logic cfg_index;
  logic [3:0] cfg_data;

  bintree_lod_height_query #(.LOG_SIDE(LOG_SIDE)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [15:0] heights [0:DEPTH-1];
  logic [7:0] levels [0:DEPTH-1];
  bit height_set [0:DEPTH-1];
  bit level_set [0:DEPTH-1];
  int grid_lw;
  int grid_lh;

  bltq_out_t height_queue [$];
  int errors;
  int queries_sent;
  int writes_sent;
  int results_seen;
  int hold_req;
  int stall_run;
  int idle_cycles;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit grid_pos(longint x, longint y, output int idx);
    longint w;
    longint h;
    w = (longint'(1) << grid_lw) + 1;
    h = (longint'(1) << grid_lh) + 1;
    idx = 0;
    if (x < 0 || y < 0 || x >= w || y >= h) return 0;
    if (y * w + x >= DEPTH) return 0;
    idx = int'(y * w + x);
    return 1;
  endfunction

  function automatic longint height_at(longint x, longint y, inout bit bad);
    int i;
    if (!grid_pos(x, y, i)) return 0;
    if (!height_set[i]) bad = 1;
    return longint'($signed(heights[i]));
  endfunction

  function automatic longint level_at(longint x, longint y, inout bit bad);
    int i;
    if (!grid_pos(x, y, i)) return 0;
    if (!level_set[i]) bad = 1;
    return longint'(levels[i]);
  endfunction

  function automatic longint halve_down(longint d);
    return d >= 0 ? d / 2 : -((-d + 1) / 2);
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Walks the bintree as the block does; bad is set when an unwritten entry is read.
  function automatic void walk_height(input bltq_in_t q, output bltq_out_t r, output bit bad);
    longint px, py, ax, ay, rx, ry, lx, ly;
    longint dx, dy, bx, by, nr, nl, dd, az, dr, dl, num, quo;
    bad = 0;
    r = '0;
    px = q.point_x; py = q.point_y;
    ax = q.apex_x; ay = q.apex_y;
    rx = q.right_x; ry = q.right_y;
    lx = q.left_x; ly = q.left_y;
    for (int step = 0; step < DESCENT_LIMIT; step++) begin
      if ((px == ax && py == ay) || (px == rx && py == ry) || (px == lx && py == ly)) begin
        r.query_height = 16'(height_at(px, py, bad));
        return;
      end
      dx = lx - rx;
      dy = ly - ry;
      if (abs_l(dx) <= 1 && abs_l(dy) <= 1) break;
      bx = rx + halve_down(dx);
      by = ry + halve_down(dy);
      nr = (px - ax) * (rx - ax) + (py - ay) * (ry - ay);
      nl = (px - ax) * (lx - ax) + (py - ay) * (ly - ay);
      if (level_at(bx, by, bad) >= longint'(q.lod_level)) begin
        if (nr >= nl) begin
          lx = rx; ly = ry; rx = ax; ry = ay;
        end else begin
          rx = lx; ry = ly; lx = ax; ly = ay;
        end
        ax = bx; ay = by;
        continue;
      end
      dd = dx * dx + dy * dy;
      az = height_at(ax, ay, bad);
      dr = height_at(rx, ry, bad) - az;
      dl = height_at(lx, ly, bad) - az;
      num = 2 * az * dd + 4 * (nl * dl + nr * dr) + dd;
      quo = num / (2 * dd);
      if (num % (2 * dd) != 0 && num < 0) quo = quo - 1;
      r.query_height = 16'(quo);
      return;
    end
    r.query_height = 16'(height_at(ax, ay, bad));
    r.base_reached = 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(bltq_in_t w);
    bltq_out_t r;
    bit bad;
    int i;
    int g;
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    case (bltq_op_t'(w.operation))
      OP_WR_HEIGHT: begin
        writes_sent++;
        if (grid_pos(w.point_x, w.point_y, i)) begin
          heights[i] = w.write_value;
          height_set[i] = 1;
        end
      end
      OP_WR_ACT: begin
        writes_sent++;
        if (grid_pos(w.point_x, w.point_y, i)) begin
          levels[i] = w.write_value[7:0];
          level_set[i] = 1;
        end
      end
      OP_QUERY: begin
        walk_height(w, r, bad);
        height_queue.push_back(r);
        queries_sent++;
      end
      default: ;
    endcase
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic bltq_in_t make_write(bltq_op_t op, int x, int y, int v);
    bltq_in_t w;
    w = bltq_in_t'($urandom());
    w.operation = op;
    w.point_x = COORD_W'(x);
    w.point_y = COORD_W'(y);
    w.write_value = 16'(v);
    return w;
  endfunction

  function automatic bltq_in_t make_query(int px, int py, int lod, int ax, int ay,
                                          int rx, int ry, int lx, int ly);
    bltq_in_t w;
    w = bltq_in_t'({$urandom(), $urandom(), $urandom()});
    w.operation = OP_QUERY;
    w.point_x = COORD_W'(px); w.point_y = COORD_W'(py); w.lod_level = 8'(lod);
    w.apex_x = COORD_W'(ax); w.apex_y = COORD_W'(ay);
    w.right_x = COORD_W'(rx); w.right_y = COORD_W'(ry);
    w.left_x = COORD_W'(lx); w.left_y = COORD_W'(ly);
    return w;
  endfunction

  function automatic bltq_in_t random_query();
    bltq_in_t w;
    bltq_out_t r;
    bit bad;
    int gw, gh, k, s, x0, y0, a;
    int cx [4];
    int cy [4];
    gw = 1 << grid_lw;
    gh = 1 << grid_lh;
    for (int t = 0; t < 300; t++) begin
      if ($urandom_range(0, 9) == 0) begin
        w = bltq_in_t'({$urandom(), $urandom(), $urandom()});
        w.operation = OP_QUERY;
      end else begin
        k = $urandom_range(1, (grid_lw < grid_lh) ? grid_lw : grid_lh);
        s = 1 << k;
        x0 = $urandom_range(0, gw / s - 1) * s;
        y0 = $urandom_range(0, gh / s - 1) * s;
        cx = '{x0, x0 + s, x0 + s, x0};
        cy = '{y0, y0, y0 + s, y0 + s};
        a = $urandom_range(0, 3);
        w = make_query(x0 + $urandom_range(0, s), y0 + $urandom_range(0, s),
                       $urandom_range(0, 255), cx[a], cy[a], cx[(a + 1) % 4],
                       cy[(a + 1) % 4], cx[(a + 3) % 4], cy[(a + 3) % 4]);
      end
      walk_height(w, r, bad);
      if (!bad) return w;
    end
    // Fall back to a vertex hit on the origin, which every fill writes.
    return make_query(0, 0, $urandom_range(0, 255), 0, 0, 2, 0, 0, 2);
  endfunction

  task automatic write_cfg(bltq_cfg_t idx, logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (v < 4'd1) v = 4'd1;
    if (v > 4'(LOG_SIDE)) v = 4'(LOG_SIDE);
    if (idx == CFG_LOG_WIDTH) grid_lw = v;
    else grid_lh = v;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (height_queue.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic fill_grid(int stride);
    for (int y = 0; y <= (1 << grid_lh); y += stride) begin
      for (int x = 0; x <= (1 << grid_lw); x += stride) begin
        send_word(make_write(OP_WR_HEIGHT, x, y, $urandom()));
        send_word(make_write(OP_WR_ACT, x, y, $urandom()));
      end
    end
  endtask

  task automatic random_words(int n, int pause_every);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_word(random_query());
      end else if (r < 92) begin
        if ($urandom_range(0, 4) == 0)
          send_word(make_write(bltq_op_t'($urandom_range(0, 1)), $urandom_range(0, 511),
                               $urandom_range(0, 511), $urandom()));
        else
          send_word(make_write(bltq_op_t'($urandom_range(0, 1)),
                               $urandom_range(0, 1 << grid_lw),
                               $urandom_range(0, 1 << grid_lh), $urandom()));
      end else begin
        send_word(make_write(OP_NONE, $urandom_range(0, 511), $urandom_range(0, 511),
                             $urandom()));
      end
      if (pause_every > 0 && k % pause_every == pause_every - 1) begin
        in_valid <= 1'b0;
        wait (height_queue.size() == 0);
        @(posedge clk);
      end
    end
  endtask

  task automatic test_directed();
    send_word(make_write(OP_WR_HEIGHT, 0, 0, -32768));
    send_word(make_write(OP_WR_HEIGHT, 256, 0, 32767));
    send_word(make_write(OP_WR_HEIGHT, 0, 256, 16'h1234));
    send_word(make_write(OP_WR_HEIGHT, 128, 128, -1));
    send_word(make_write(OP_WR_HEIGHT, 128, 0, 4242));
    send_word(make_write(OP_WR_HEIGHT, 10, 10, 777));
    send_word(make_write(OP_WR_ACT, 128, 128, 16'hff00));
    send_word(make_write(OP_WR_ACT, 128, 0, 0));
    send_word(make_write(OP_WR_ACT, 0, 128, 16'h00ff));
    send_word(make_write(OP_WR_HEIGHT, 400, 5, 99));
    send_word(make_write(OP_NONE, 511, 511, -1));
    send_word(make_query(0, 0, 0, 0, 0, 256, 0, 0, 256));
    send_word(make_query(256, 0, 255, 0, 0, 256, 0, 0, 256));
    send_word(make_query(0, 256, 255, 0, 0, 256, 0, 0, 256));
    send_word(make_query(100, 50, 1, 0, 0, 256, 0, 0, 256));
    send_word(make_query(200, 10, 1, 0, 0, 256, 0, 0, 256));
    send_word(make_query(128, 0, 0, 0, 0, 256, 0, 0, 256));
    send_word(make_query(20, 20, 0, 10, 10, 11, 10, 10, 11));
    send_word(make_query(20, 20, 3, 10, 10, 10, 10, 10, 10));
    send_word(make_query(300, 300, 0, 300, 300, 511, 0, 0, 511));
    send_word(make_query(511, 511, 255, 0, 0, 256, 0, 0, 256));
    drain();
  endtask

  task automatic test_phase(logic [3:0] lw, logic [3:0] lh, int stride, int n,
                            int hold, int pause_every);
    write_cfg(CFG_LOG_WIDTH, lw);
    write_cfg(CFG_LOG_HEIGHT, lh);
    fill_grid(stride);
    no_gaps = (hold > 0);
    hold_req = hold;
    random_words(n, pause_every);
    no_gaps = 0;
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (hold_req > 0) begin
      out_stall <= 1'b1;
      hold_req <= hold_req - 1;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 99) < 3) begin
      stall_run <= $urandom_range(10, 50);
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk) begin
    bltq_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (height_queue.size() == 0) begin
        $error("unexpected result word: query_height %0d base_reached %0b",
               out_word.query_height, out_word.base_reached);
        errors++;
      end else begin
        exp_r = height_queue.pop_front();
        if (out_word.query_height !== exp_r.query_height) begin
          $error("query_height: expected %0d, actual %0d", exp_r.query_height,
                 out_word.query_height);
          errors++;
        end
        if (out_word.base_reached !== exp_r.base_reached) begin
          $error("base_reached: expected %0b, actual %0b", exp_r.base_reached,
                 out_word.base_reached);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (height_queue.size() == 0 && !in_valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_LOG_WIDTH;
    cfg_data = '0;
    rst_n = 1'b0;
    hold_req = 0;
    no_gaps = 0;
    errors = 0;
    grid_lw = 8;
    grid_lh = 8;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_phase(4'd8, 4'd8, 32, 120, 0, 0);
    test_phase(4'd0, 4'd0, 1, 80, 0, 0);
    test_phase(4'd3, 4'd2, 1, 100, 300, 0);
    test_phase(4'd2, 4'd3, 1, 100, 0, 40);
    test_phase(4'd4, 4'd3, 1, 90, 0, 0);
    test_phase(4'd15, 4'd15, 64, 70, 0, 0);
    drain();
    $display("Covered %0d queries and %0d writes over grid sizes from 3x3 to 257x257,",
             queries_sent, writes_sent);
    $display("with %0d results checked under random gaps, stalls and one long hold-off.",
             results_seen);
    if (errors == 0 && height_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

FILE: bintree_lod_height_query.f
hw/rtl/bltq_pkg.sv
hw/rtl/bltq_div.sv
hw/rtl/bintree_lod_height_query.sv
sim/tb.sv
